FILE: src/jtsc_pkg.sv
// ============================================================================
// JSON token checker package
// Token codes, result status codes and the stack control bundle shared by
// the checker's modules.
// ============================================================================
package jtsc_pkg;

    // Width of the fields that the token and result beats carry.
    localparam int TOKEN_W  = 4;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 6;
    localparam int DEPTH_W  = 6;

    // Token codes from the lexer.
    localparam logic [TOKEN_W-1:0] TK_LBRACE   = 4'd0;
    localparam logic [TOKEN_W-1:0] TK_RBRACE   = 4'd1;
    localparam logic [TOKEN_W-1:0] TK_LBRACKET = 4'd2;
    localparam logic [TOKEN_W-1:0] TK_RBRACKET = 4'd3;
    localparam logic [TOKEN_W-1:0] TK_COMMA    = 4'd4;
    localparam logic [TOKEN_W-1:0] TK_COLON    = 4'd5;
    localparam logic [TOKEN_W-1:0] TK_QUOTE    = 4'd6;
    localparam logic [TOKEN_W-1:0] TK_BODY     = 4'd7;
    localparam logic [TOKEN_W-1:0] TK_INT      = 4'd8;
    localparam logic [TOKEN_W-1:0] TK_NULL     = 4'd9;
    localparam logic [TOKEN_W-1:0] TK_TRUE     = 4'd10;
    localparam logic [TOKEN_W-1:0] TK_FALSE    = 4'd11;

    // Result status codes; the two fault codes are also the sticky fault.
    localparam logic [STATUS_W-1:0] ST_PENDING  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_VALID    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SYNTAX   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    // Reset value of the depth limit register.
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd32;

    // Shift command for the row of stack cells.
    typedef struct packed {
        logic push;      // shift down, new bit enters the top cell
        logic pop;       // shift up, top bit leaves
        logic push_bit;  // 1 object, 0 array
    } stack_op_t;

endpackage

FILE: src/jtsc_cell.sv
// ============================================================================
// Stack cell
// One bit of the container stack. On a push it takes the bit of the cell
// above it, on a pop the bit of the cell below it, otherwise it holds.
// ============================================================================
module jtsc_cell
(
    input  logic                clk,
    input  jtsc_pkg::stack_op_t op,
    input  logic                above,
    input  logic                below,
    output logic                kind
);

    logic kind_reg;
    logic kind_next;

    // Select the neighbor that moves into this cell.
    always_comb
    begin
        kind_next = kind_reg;
        if (op.push)
        begin
            kind_next = above;
        end
        else if (op.pop)
        begin
            kind_next = below;
        end
    end

    // Stack contents are only read where pushed, so no reset is needed.
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule

FILE: src/jtsc_ctrl.sv
// ============================================================================
// Grammar controller
// Holds the parse mode, open container count and sticky fault, decides the
// stack command for each token beat and forms the result status.
// ============================================================================
module jtsc_ctrl
#(
    parameter int MAX_NEST = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [jtsc_pkg::TOKEN_W-1:0]        token,
    input  logic                                last,
    input  logic [jtsc_pkg::DEPTH_W-1:0]        max_depth,
    input  logic                                top_kind,
    output jtsc_pkg::stack_op_t                 op,
    output logic [jtsc_pkg::STATUS_W-1:0]       status,
    output logic [jtsc_pkg::LEVEL_W-1:0]        nest_level
);

    localparam int CNT_W = $clog2(MAX_NEST + 1);
    localparam int CMP_W = (CNT_W > jtsc_pkg::DEPTH_W) ? CNT_W : jtsc_pkg::DEPTH_W;
    localparam logic [CMP_W-1:0] NEST_CAP = CMP_W'(MAX_NEST);

    // Parse mode codes.
    localparam logic [3:0] MD_START       = 4'd0;
    localparam logic [3:0] MD_OBJ_FIRST   = 4'd1;
    localparam logic [3:0] MD_KEY_OPEN    = 4'd2;
    localparam logic [3:0] MD_KEY_BODY    = 4'd3;
    localparam logic [3:0] MD_KEY_CLOSE   = 4'd4;
    localparam logic [3:0] MD_COLON       = 4'd5;
    localparam logic [3:0] MD_VALUE       = 4'd6;
    localparam logic [3:0] MD_ARR_FIRST   = 4'd7;
    localparam logic [3:0] MD_VSTR_BODY   = 4'd8;
    localparam logic [3:0] MD_VSTR_CLOSE  = 4'd9;
    localparam logic [3:0] MD_AFTER_VALUE = 4'd10;
    localparam logic [3:0] MD_DONE        = 4'd11;

    logic [3:0]                       mode_reg;
    logic [3:0]                       mode_next;
    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic [jtsc_pkg::STATUS_W-1:0]    fault_reg;
    logic [jtsc_pkg::STATUS_W-1:0]    fault_next;

    logic [CMP_W-1:0] depth_ext;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] limit;
    logic             at_limit;
    logic             want_push;
    logic             want_pop;
    logic             kind_sel;
    logic             bad;
    logic [3:0]       mode_adv;
    logic             top_obj;

    // Effective depth limit is the smaller of the register and the stack size.
    assign depth_ext = CMP_W'(max_depth);
    assign count_ext = CMP_W'(count_reg);
    assign limit     = (depth_ext < NEST_CAP) ? depth_ext : NEST_CAP;
    assign at_limit  = (count_ext >= limit);
    assign top_obj   = (count_reg == '0) ? 1'b1 : top_kind;

    // Grammar position decode: what the token asks of the stack and mode.
    always_comb
    begin
        want_push = 1'b0;
        want_pop  = 1'b0;
        kind_sel  = 1'b0;
        bad       = 1'b0;
        mode_adv  = mode_reg;
        unique case (mode_reg) inside
            MD_START:
            begin
                if (token == jtsc_pkg::TK_LBRACE)
                begin
                    want_push = 1'b1;
                    kind_sel  = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            MD_OBJ_FIRST:
            begin
                if (token == jtsc_pkg::TK_RBRACE)
                begin
                    want_pop = 1'b1;
                    kind_sel = 1'b1;
                end
                else if (token == jtsc_pkg::TK_QUOTE)
                begin
                    mode_adv = MD_KEY_BODY;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            MD_KEY_OPEN:
            begin
                if (token == jtsc_pkg::TK_QUOTE) mode_adv = MD_KEY_BODY;
                else bad = 1'b1;
            end
            MD_KEY_BODY:
            begin
                if (token == jtsc_pkg::TK_BODY) mode_adv = MD_KEY_CLOSE;
                else bad = 1'b1;
            end
            MD_KEY_CLOSE:
            begin
                if (token == jtsc_pkg::TK_QUOTE) mode_adv = MD_COLON;
                else bad = 1'b1;
            end
            MD_COLON:
            begin
                if (token == jtsc_pkg::TK_COLON) mode_adv = MD_VALUE;
                else bad = 1'b1;
            end
            MD_VALUE, MD_ARR_FIRST:
            begin
                if ((mode_reg == MD_ARR_FIRST) && (token == jtsc_pkg::TK_RBRACKET))
                begin
                    want_pop = 1'b1;
                end
                else if (token == jtsc_pkg::TK_QUOTE)
                begin
                    mode_adv = MD_VSTR_BODY;
                end
                else if ((token == jtsc_pkg::TK_INT) || (token == jtsc_pkg::TK_NULL) ||
                         (token == jtsc_pkg::TK_TRUE) || (token == jtsc_pkg::TK_FALSE))
                begin
                    mode_adv = MD_AFTER_VALUE;
                end
                else if (token == jtsc_pkg::TK_LBRACE)
                begin
                    want_push = 1'b1;
                    kind_sel  = 1'b1;
                end
                else if (token == jtsc_pkg::TK_LBRACKET)
                begin
                    want_push = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            MD_VSTR_BODY:
            begin
                if (token == jtsc_pkg::TK_BODY) mode_adv = MD_VSTR_CLOSE;
                else bad = 1'b1;
            end
            MD_VSTR_CLOSE:
            begin
                if (token == jtsc_pkg::TK_QUOTE) mode_adv = MD_AFTER_VALUE;
                else bad = 1'b1;
            end
            MD_AFTER_VALUE:
            begin
                if (token == jtsc_pkg::TK_COMMA)
                begin
                    mode_adv = top_obj ? MD_KEY_OPEN : MD_VALUE;
                end
                else if (token == jtsc_pkg::TK_RBRACE)
                begin
                    want_pop = 1'b1;
                    kind_sel = 1'b1;
                end
                else if (token == jtsc_pkg::TK_RBRACKET)
                begin
                    want_pop = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            default:
            begin
                // Anything after the top object has closed is an error.
                bad = 1'b1;
            end
        endcase
    end

    // Resolve pushes and pops against the limit and the top container kind.
    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        fault_next  = fault_reg;
        op.push     = 1'b0;
        op.pop      = 1'b0;
        op.push_bit = kind_sel;
        if (fault_reg == jtsc_pkg::ST_PENDING)
        begin
            if (bad)
            begin
                fault_next = jtsc_pkg::ST_SYNTAX;
            end
            else if (want_push)
            begin
                if (at_limit)
                begin
                    fault_next = jtsc_pkg::ST_OVERFLOW;
                end
                else
                begin
                    op.push    = accept;
                    count_next = count_reg + CNT_W'(1);
                    mode_next  = kind_sel ? MD_OBJ_FIRST : MD_ARR_FIRST;
                end
            end
            else if (want_pop)
            begin
                if ((count_reg == '0) || (top_kind != kind_sel))
                begin
                    fault_next = jtsc_pkg::ST_SYNTAX;
                end
                else
                begin
                    op.pop     = accept;
                    count_next = count_reg - CNT_W'(1);
                    mode_next  = (count_reg == CNT_W'(1)) ? MD_DONE : MD_AFTER_VALUE;
                end
            end
            else
            begin
                mode_next = mode_adv;
            end
        end
    end

    // Result of this beat, taken before the end-of-document clear.
    always_comb
    begin
        if (fault_next != jtsc_pkg::ST_PENDING)
        begin
            status = fault_next;
        end
        else if (last)
        begin
            status = (mode_next == MD_DONE) ? jtsc_pkg::ST_VALID : jtsc_pkg::ST_SYNTAX;
        end
        else
        begin
            status = jtsc_pkg::ST_PENDING;
        end
    end

    assign nest_level = jtsc_pkg::LEVEL_W'(CMP_W'(count_next));

    // Parser state; the last token of a document returns it to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MD_START;
            count_reg <= '0;
            fault_reg <= jtsc_pkg::ST_PENDING;
        end
        else if (accept)
        begin
            if (last)
            begin
                mode_reg  <= MD_START;
                count_reg <= '0;
                fault_reg <= jtsc_pkg::ST_PENDING;
            end
            else
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                fault_reg <= fault_next;
            end
        end
    end

endmodule

FILE: src/json_token_syntax_checker.sv
// ============================================================================
// JSON token syntax checker
// Checks lexer tokens against the JSON grammar with a mode register and a
// shifting row of one-bit container cells, one result beat per token beat.
// ============================================================================
// The block takes one token beat per clock cycle while tok_stall is low and
// returns one registered result beat for each accepted token; the grammar
// decode in the controller is combinational. The container stack is a row
// of MAX_NEST one-bit cells with the innermost container in the first cell;
// every push or pop shifts the whole row by one place in the same cycle. A
// two-entry output buffer lets token beats keep flowing while one result
// beat waits downstream; token stall rises only when both entries are full.
// There is no clearing pass after reset. The depth limit register may be
// written only while the block is idle. After the token beat marked last
// the block starts a new document.
module json_token_syntax_checker
#(
    parameter int MAX_NEST = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration.
    input  logic                                cfg_we,
    input  logic [jtsc_pkg::DEPTH_W-1:0]        cfg_data,
    // Token channel.
    input  logic                                tok_valid,
    output logic                                tok_stall,
    input  logic [jtsc_pkg::TOKEN_W-1:0]        token,
    input  logic                                last,
    // Result channel.
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [jtsc_pkg::STATUS_W-1:0]       status,
    output logic [jtsc_pkg::LEVEL_W-1:0]        nest_level
);

    logic [jtsc_pkg::DEPTH_W-1:0]  max_depth_reg;
    logic                          accept;
    logic                          take;
    jtsc_pkg::stack_op_t           op;
    logic [MAX_NEST-1:0]           kinds;
    logic [jtsc_pkg::STATUS_W-1:0] new_status;
    logic [jtsc_pkg::LEVEL_W-1:0]  new_level;

    logic                          out_valid_reg;
    logic [jtsc_pkg::STATUS_W-1:0] out_status_reg;
    logic [jtsc_pkg::LEVEL_W-1:0]  out_level_reg;
    logic                          skid_valid_reg;
    logic [jtsc_pkg::STATUS_W-1:0] skid_status_reg;
    logic [jtsc_pkg::LEVEL_W-1:0]  skid_level_reg;

    // Depth limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= jtsc_pkg::DEPTH_RESET;
        end
        else if (cfg_we)
        begin
            max_depth_reg <= cfg_data;
        end
    end

    // Handshake on both sides.
    assign tok_stall = skid_valid_reg;
    assign accept    = tok_valid && !skid_valid_reg;
    assign take      = out_valid_reg && !res_stall;

    // Grammar controller.
    jtsc_ctrl #(
        .MAX_NEST (MAX_NEST)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .token      (token),
        .last       (last),
        .max_depth  (max_depth_reg),
        .top_kind   (kinds[0]),
        .op         (op),
        .status     (new_status),
        .nest_level (new_level)
    );

    // Row of stack cells, innermost container first.
    for (genvar i = 0; i < MAX_NEST; i++)
    begin : g_cell
        logic above;
        logic below;
        if (i == 0)
        begin : g_first
            assign above = op.push_bit;
        end
        else
        begin : g_mid_up
            assign above = kinds[i-1];
        end
        if (i == MAX_NEST - 1)
        begin : g_end
            assign below = 1'b0;
        end
        else
        begin : g_mid_down
            assign below = kinds[i+1];
        end
        jtsc_cell u_cell (
            .clk   (clk),
            .op    (op),
            .above (above),
            .below (below),
            .kind  (kinds[i])
        );
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_status_reg <= skid_status_reg;
                out_level_reg  <= skid_level_reg;
            end
            else
            begin
                out_status_reg <= new_status;
                out_level_reg  <= new_level;
            end
        end
        else if (accept)
        begin
            skid_status_reg <= new_status;
            skid_level_reg  <= new_level;
        end
    end

    assign res_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign nest_level = out_level_reg;

endmodule
